/* hw/rtl/hds_pkg.sv */
// Package for the heat diffusion stencil: value widths, configuration
// defaults and the reciprocal used for the divide-by-five.
// No dependencies.
package hds_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int VAL_W         = FRACTION_BITS + 1;   // unsigned Q1.16
    localparam int SUM_W         = VAL_W + 3;           // five values plus rounding
    localparam int CFG_W         = 6;                   // grid_side register width

    localparam int GRID_SIDE_DEF   = 32;
    localparam int GRID_SIDE_RESET = 32;
    localparam int SIDE_MIN        = 2;

    // floor(x / 5) == (x * RECIP5) >> RECIP_SHIFT for every x below 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + 2;
    localparam int RECIP_W     = SUM_W;
    localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((1 << RECIP_SHIFT) / 5 + 1);

    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(2);

endpackage

/* hw/rtl/hds_if.sv */
// Stream interfaces for the heat diffusion stencil: grid cells in,
// updated cells out. Depends on hds_pkg.
interface hds_in_if
    import hds_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface hds_out_if
    import hds_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] new_value;
    logic             last_of_grid;

    modport source (output valid, output new_value, output last_of_grid, input ready);
    modport sink   (input valid, input new_value, input last_of_grid, output ready);
endinterface

/* hw/rtl/heat_diffusion_stencil_step.sv */
// Heat diffusion stencil, top level: one Jacobi step of a 5-point stencil.
// Depends on hds_pkg, hds_if, hds_line, hds_cell, hds_div5.
//
// Grid cells arrive row-major as unsigned Q1.16 beats on grid_stream; each
// updated cell is (up + down + left + right + centre + 2) / 5, an edge
// neighbour being replaced by the centre. The cell at row r >= 1 releases the
// updated cell of row r-1 in the same column; row 0 releases nothing. After
// the last cell of the grid the block flushes the last row: it holds
// grid_stream.ready low and emits n beats, the final one flagged with
// last_of_grid. Throughput is one cell per clock while update_stream takes
// beats and no flush is under way; a result beat passes through the sum
// register and then the result register. Two chains of GRID_SIDE cells hold
// the previous two rows, each shifting once per cell; writing grid_side
// (clamped to 2..GRID_SIDE) restarts the pass at row 0, column 0. Write it
// only while the block is idle.
module heat_diffusion_stencil_step
    import hds_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    hds_in_if.sink           grid_stream,
    hds_out_if.source        update_stream
);

    localparam int IDX_W = $clog2(GRID_SIDE);
    localparam int N_W   = $clog2(GRID_SIDE + 1);
    localparam int SIDE_RST = (GRID_SIDE_RESET < GRID_SIDE) ? GRID_SIDE_RESET : GRID_SIDE;

    // control state
    logic [N_W-1:0]   side_reg;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic             flush_reg, flush_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg;

    // payload
    logic [SUM_W-1:0] sum_reg;
    logic             s1_last_reg;
    logic [VAL_W-1:0] left_reg;

    logic [IDX_W-1:0] side_m1;
    logic             out_adv, step_ok, in_acc, step;
    logic [VAL_W-1:0] a_tail, a_next, b_tail;
    logic [VAL_W-1:0] ctr, up, dn, lf, rt;
    logic             col_last, row_last, emit, last_flag;
    logic [SUM_W-1:0] sum;

    assign side_m1 = IDX_W'(side_reg - N_W'(1));
    assign col_last = (col_reg == side_m1);
    assign row_last = (row_reg == side_m1);

    // handshake: the result register parts the two sides
    assign out_adv = !out_valid_reg || update_stream.ready;
    assign step_ok = !s1_valid_reg || out_adv;
    assign grid_stream.ready = step_ok && !flush_reg;
    assign in_acc  = grid_stream.valid && grid_stream.ready;
    assign step    = in_acc || (flush_reg && step_ok);

    // row r-1 and row r-2, each n shifts deep
    hds_line #(.DEPTH (GRID_SIDE)) u_line_a (
        .clk       (clk),
        .shift_en  (step),
        .entry_idx (side_m1),
        .din       (grid_stream.cell_value),
        .tail      (a_tail),
        .tail_next (a_next)
    );

    hds_line #(.DEPTH (GRID_SIDE)) u_line_b (
        .clk       (clk),
        .shift_en  (step),
        .entry_idx (side_m1),
        .din       (a_tail),
        .tail      (b_tail),
        .tail_next ()
    );

    // stencil taps; in flush the missing row below is replaced by the centre
    always_comb
    begin
        ctr = a_tail;
        up  = (!flush_reg && row_reg == IDX_W'(1)) ? ctr : b_tail;
        dn  = flush_reg ? ctr : grid_stream.cell_value;
        lf  = (col_reg == '0) ? ctr : left_reg;
        rt  = col_last ? ctr : a_next;
        sum = SUM_W'(up) + SUM_W'(dn) + SUM_W'(lf) + SUM_W'(rt) + SUM_W'(ctr)
              + ROUND_BIAS;
        emit      = flush_reg || (row_reg != '0);
        last_flag = flush_reg && col_last;
    end

    // position walk: advance column, then row; enter flush after the last cell
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        flush_next = flush_reg;
        if (step)
        begin
            if (!col_last)
            begin
                col_next = col_reg + IDX_W'(1);
            end
            else
            begin
                col_next = '0;
                if (flush_reg)
                begin
                    flush_next = 1'b0;
                    row_next   = '0;
                end
                else if (row_last)
                begin
                    flush_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + IDX_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        if (step)
        begin
            s1_valid_next = emit;
        end
        else if (out_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg      <= N_W'(SIDE_RST);
            row_reg       <= '0;
            col_reg       <= '0;
            flush_reg     <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (cfg_wr_en)
            begin
                // clamp and restart the pass
                if (cfg_wr_data < CFG_W'(SIDE_MIN))
                begin
                    side_reg <= N_W'(SIDE_MIN);
                end
                else if (cfg_wr_data > CFG_W'(GRID_SIDE))
                begin
                    side_reg <= N_W'(GRID_SIDE);
                end
                else
                begin
                    side_reg <= N_W'(cfg_wr_data);
                end
                row_reg   <= '0;
                col_reg   <= '0;
                flush_reg <= 1'b0;
            end
            else
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                flush_reg <= flush_next;
            end
        end
    end

    // hold the sum for the divider, and the centre as the next cell's left neighbour
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sum_reg     <= sum;
            s1_last_reg <= last_flag;
            left_reg    <= a_tail;
        end
    end

    hds_div5 u_div5 (
        .clk      (clk),
        .load     (out_adv && s1_valid_reg),
        .sum      (sum_reg),
        .last_in  (s1_last_reg),
        .quotient (update_stream.new_value),
        .last_out (update_stream.last_of_grid)
    );

    assign update_stream.valid = out_valid_reg;

`ifndef SYNTHESIS
    a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> !grid_stream.ready)
        else $error("input beat offered ready during flush");

    a_row0_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && row_reg == '0) |=> !s1_valid_reg)
        else $error("row 0 cell produced a result");

    a_flush_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && flush_reg && col_last) |=> (!flush_reg && row_reg == '0 && col_reg == '0))
        else $error("flush did not wrap to the grid origin");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(sum_reg)))
        else $error("stalled sum stage lost its beat");
`endif

endmodule

/* hw/rtl/hds_cell.sv */
// One cell of a row line: holds a single grid value.
// Depends on hds_pkg.
module hds_cell
    import hds_pkg::*;
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic             is_entry,
    input  logic [VAL_W-1:0] inject,
    input  logic [VAL_W-1:0] from_nbr,
    output logic [VAL_W-1:0] value
);

    logic [VAL_W-1:0] value_reg;

    // take the new value at the entry point, else the upstream neighbour
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= is_entry ? inject : from_nbr;
        end
    end

    assign value = value_reg;

endmodule

/* hw/rtl/hds_line.sv */
// Row line: a chain of hds_cell that delays values by exactly n shifts,
// with the entry point chosen by the grid side. Depends on hds_pkg, hds_cell.
module hds_line
    import hds_pkg::*;
#(
    parameter  int DEPTH = GRID_SIDE_DEF,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic [IDX_W-1:0] entry_idx,
    input  logic [VAL_W-1:0] din,
    output logic [VAL_W-1:0] tail,
    output logic [VAL_W-1:0] tail_next
);

    logic [VAL_W-1:0] q [DEPTH];

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [VAL_W-1:0] nbr;

        if (k == DEPTH - 1)
        begin : g_top
            assign nbr = din;
        end
        else
        begin : g_mid
            assign nbr = q[k+1];
        end

        hds_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .is_entry (entry_idx == IDX_W'(k)),
            .inject   (din),
            .from_nbr (nbr),
            .value    (q[k])
        );
    end

    assign tail      = q[0];
    assign tail_next = q[1];

endmodule

/* hw/rtl/hds_div5.sv */
// Divide-by-five output stage: reciprocal multiply into the result register.
// Depends on hds_pkg.
module hds_div5
    import hds_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [SUM_W-1:0] sum,
    input  logic             last_in,
    output logic [VAL_W-1:0] quotient,
    output logic             last_out
);

    logic [SUM_W+RECIP_W-1:0] prod;
    logic [VAL_W-1:0]         quot_reg;
    logic                     last_reg;

    assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP5);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= prod[RECIP_SHIFT +: VAL_W];
            last_reg <= last_in;
        end
    end

    assign quotient = quot_reg;
    assign last_out = last_reg;

endmodule
